// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define TCW_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TCW_ASSERT(lbl, clk, rstn, prop)
`define TCW_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: rtl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;

  typedef enum logic [2:0] {
    REQ_PUT    = 3'd0,
    REQ_SHOW   = 3'd1,
    REQ_READ   = 3'd2,
    REQ_SETCUR = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_SCR_FILL,
    ST_CLR,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic cap_rd;
    logic copy_rd;
    logic copy_wr;
    logic zero_wr;
    logic sw_inc;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    req_e req;
    logic ok;
    logic scroll;
    logic out_free;
    logic sw_copy_end;
    logic sw_end;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: rtl/text_console_writer_top.sv
// Text console writer: a screen of SCREEN_ROWS x SCREEN_COLS cells (character and
// attribute bytes) with a cursor. Requests arrive on the input channel (valid/stall)
// as one word each; every request returns exactly one result word on the output
// channel with the read cell, the cursor after the request and scroll/reject flags.
// The block holds one request at a time. Any request other than an in-range read, a
// scrolling put or a clear is carried out in the execute state and, if the output
// register is free, pushed from there to the result register; an in-range read
// passes through a read-wait state first. No new request is taken until the block
// is back in its idle state. A put that scrolls copies the cell store up one row,
// with a read state and a write state per copied cell, then zeroes the bottom row.
// Clear writes every cell. After reset a clearing pass zeroes all SCREEN_ROWS x
// SCREEN_COLS cells (2000 by default) while in_stall_o stays high. The output
// register lets the next request be accepted while a result waits; a request that
// finishes while the receiver still stalls waits in a done state until the output
// register frees.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLS = DEF_COLS,
  parameter int SCREEN_ROWS = DEF_ROWS
) (
  input  wire  logic              clk_i,
  input  wire  logic              rst_ni,
  input  wire  logic              in_valid_i,
  output       logic              in_stall_o,
  input  wire  logic [2:0]        req_type_i,
  input  wire  logic [CHAR_W-1:0] char_code_i,
  input  wire  logic [CHAR_W-1:0] attr_byte_i,
  input  wire  logic [COL_W-1:0]  column_i,
  input  wire  logic [ROW_W-1:0]  row_i,
  input  wire  logic              string_end_i,
  output       logic              out_valid_o,
  input  wire  logic              out_stall_i,
  output       logic [CHAR_W-1:0] cell_char_o,
  output       logic [CHAR_W-1:0] cell_attr_o,
  output       logic [COL_W-1:0]  cursor_col_o,
  output       logic [ROW_W-1:0]  cursor_line_o,
  output       logic              did_scroll_o,
  output       logic              rejected_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcw_datapath #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_type_i),
    .char_code_i   (char_code_i),
    .attr_byte_i   (attr_byte_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .string_end_i  (string_end_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .cell_char_o   (cell_char_o),
    .cell_attr_o   (cell_attr_o),
    .cursor_col_o  (cursor_col_o),
    .cursor_line_o (cursor_line_o),
    .did_scroll_o  (did_scroll_o),
    .rejected_o    (rejected_o)
  );

endmodule
`default_nettype wire

// File: rtl/tcw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLS = DEF_COLS,
  parameter int SCREEN_ROWS = DEF_ROWS
) (
  input  wire  logic              clk_i,
  input  wire  logic              rst_ni,
  input  wire  dp_cmd_t           cmd_i,
  output       dp_sts_t           sts_o,
  input  wire  logic [2:0]        req_type_i,
  input  wire  logic [CHAR_W-1:0] char_code_i,
  input  wire  logic [CHAR_W-1:0] attr_byte_i,
  input  wire  logic [COL_W-1:0]  column_i,
  input  wire  logic [ROW_W-1:0]  row_i,
  input  wire  logic              string_end_i,
  input  wire  logic              out_stall_i,
  output       logic              out_valid_o,
  output       logic [CHAR_W-1:0] cell_char_o,
  output       logic [CHAR_W-1:0] cell_attr_o,
  output       logic [COL_W-1:0]  cursor_col_o,
  output       logic [ROW_W-1:0]  cursor_line_o,
  output       logic              did_scroll_o,
  output       logic              rejected_o
);

  localparam int NCELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W = $clog2(NCELLS);

  logic [2:0]        req_q;
  logic [CHAR_W-1:0] ch_q, attr_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic              last_q;

  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic              stopped_q, stopped_d;
  logic [ADDR_W-1:0] sw_q, sw_d;

  logic [CHAR_W-1:0] res_char_q, res_char_d, res_attr_q, res_attr_d;
  logic              res_scroll_q, res_scroll_d, res_rej_q, res_rej_d;

  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q, out_attr_q;
  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic              out_scroll_q, out_rej_q;

  logic [2*CHAR_W-1:0] mem [NCELLS];
  logic [2*CHAR_W-1:0] rdata_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_wa, mem_ra, req_idx, cur_idx;
  logic [2*CHAR_W-1:0] mem_wd;

  req_e         req;
  logic         ok, put_act, put_char, is_nul, is_nl, wrap, at_bottom, nxt_line, scroll;
  logic [COL_W:0] col_inc;
  logic [ROW_W:0] row_inc;

  assign req = req_e'(req_q);
  assign ok  = ({1'b0, col_q} < (COL_W + 1)'(SCREEN_COLS)) &&
               ({1'b0, row_q} < (ROW_W + 1)'(SCREEN_ROWS));

  assign req_idx = ADDR_W'(row_q) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col_q);
  assign cur_idx = ADDR_W'(cur_row_q) * ADDR_W'(SCREEN_COLS) + ADDR_W'(cur_col_q);

  assign is_nul    = (ch_q == CH_NUL);
  assign is_nl     = (ch_q == CH_NEWLINE);
  assign put_act   = (req == REQ_PUT) && !stopped_q;
  assign put_char  = put_act && !is_nul && !is_nl;
  assign col_inc   = {1'b0, cur_col_q} + (COL_W + 1)'(1);
  assign row_inc   = {1'b0, cur_row_q} + (ROW_W + 1)'(1);
  assign wrap      = col_inc >= (COL_W + 1)'(SCREEN_COLS);
  assign at_bottom = row_inc >= (ROW_W + 1)'(SCREEN_ROWS);
  assign nxt_line  = put_act && (is_nl || (put_char && wrap));
  assign scroll    = nxt_line && at_bottom;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      ch_q   <= char_code_i;
      attr_q <= attr_byte_i;
      col_q  <= column_i;
      row_q  <= row_i;
      last_q <= string_end_i;
    end
  end

  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    stopped_d = stopped_q;
    if (cmd_i.exec) begin
      case (req)
        REQ_PUT: begin
          if (put_char) begin
            cur_col_d = col_inc[COL_W-1:0];
          end
          if (nxt_line) begin
            cur_col_d = '0;
            cur_row_d = at_bottom ? ROW_W'(SCREEN_ROWS - 1) : row_inc[ROW_W-1:0];
          end
          if (last_q) begin
            stopped_d = 1'b0;
          end else if (put_act && is_nul) begin
            stopped_d = 1'b1;
          end
        end
        REQ_SETCUR: begin
          if (ok) begin
            cur_col_d = col_q;
            cur_row_d = row_q;
          end
        end
        REQ_CLEAR: begin
          cur_col_d = '0;
          cur_row_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sw_d = sw_q;
    if (cmd_i.exec) begin
      sw_d = '0;
    end else if (cmd_i.sw_inc) begin
      sw_d = sw_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      stopped_q <= 1'b0;
      sw_q      <= '0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      stopped_q <= stopped_d;
      sw_q      <= sw_d;
    end
  end

  always_comb begin
    res_char_d   = res_char_q;
    res_attr_d   = res_attr_q;
    res_scroll_d = res_scroll_q;
    res_rej_d    = res_rej_q;
    if (cmd_i.exec) begin
      res_char_d   = '0;
      res_attr_d   = '0;
      res_scroll_d = scroll;
      res_rej_d    = ((req == REQ_SHOW) || (req == REQ_READ) || (req == REQ_SETCUR)) && !ok;
    end else if (cmd_i.cap_rd) begin
      res_char_d = rdata_q[CHAR_W-1:0];
      res_attr_d = rdata_q[2*CHAR_W-1:CHAR_W];
    end
  end

  always_ff @(posedge clk_i) begin
    res_char_q   <= res_char_d;
    res_attr_q   <= res_attr_d;
    res_scroll_q <= res_scroll_d;
    res_rej_q    <= res_rej_d;
  end

  always_comb begin
    mem_we = cmd_i.copy_wr || cmd_i.zero_wr ||
             (cmd_i.exec && (put_char || ((req == REQ_SHOW) && ok)));
    if (cmd_i.copy_wr || cmd_i.zero_wr) begin
      mem_wa = sw_q;
    end else if (req == REQ_SHOW) begin
      mem_wa = req_idx;
    end else begin
      mem_wa = cur_idx;
    end
    if (cmd_i.zero_wr) begin
      mem_wd = '0;
    end else if (cmd_i.copy_wr) begin
      mem_wd = rdata_q;
    end else begin
      mem_wd = {attr_q, ch_q};
    end
    mem_ra = cmd_i.copy_rd ? (sw_q + ADDR_W'(SCREEN_COLS)) : req_idx;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_char_q   <= res_char_d;
      out_attr_q   <= res_attr_d;
      out_col_q    <= cur_col_d;
      out_row_q    <= cur_row_d;
      out_scroll_q <= res_scroll_d;
      out_rej_q    <= res_rej_d;
    end
  end

  assign sts_o.req         = req;
  assign sts_o.ok          = ok;
  assign sts_o.scroll      = scroll;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;
  assign sts_o.sw_copy_end = (sw_q == ADDR_W'(NCELLS - SCREEN_COLS - 1));
  assign sts_o.sw_end      = (sw_q == ADDR_W'(NCELLS - 1));

  assign out_valid_o   = out_valid_q;
  assign cell_char_o   = out_char_q;
  assign cell_attr_o   = out_attr_q;
  assign cursor_col_o  = out_col_q;
  assign cursor_line_o = out_row_q;
  assign did_scroll_o  = out_scroll_q;
  assign rejected_o    = out_rej_q;

  `TCW_ASSERT(a_cursor_in_bounds, clk_i, rst_ni,
              ({1'b0, cur_col_q} < (COL_W + 1)'(SCREEN_COLS)) &&
              ({1'b0, cur_row_q} < (ROW_W + 1)'(SCREEN_ROWS)))
  `TCW_ASSERT(a_copy_in_range, clk_i, rst_ni,
              cmd_i.copy_wr |-> (sw_q < ADDR_W'(NCELLS - SCREEN_COLS)))

endmodule
`default_nettype wire

// File: rtl/tcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire  logic    clk_i,
  input  wire  logic    rst_ni,
  input  wire  logic    in_valid_i,
  output       logic    in_stall_o,
  input  wire  dp_sts_t sts_i,
  output       dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        exec_more;

  assign exec_more = ((sts_i.req == REQ_READ) && sts_i.ok) ||
                     ((sts_i.req == REQ_PUT) && sts_i.scroll) ||
                     (sts_i.req == REQ_CLEAR);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sts_i.sw_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if ((sts_i.req == REQ_READ) && sts_i.ok) begin
          state_d = ST_RD_WAIT;
        end else if ((sts_i.req == REQ_PUT) && sts_i.scroll) begin
          state_d = ST_SCR_RD;
        end else if (sts_i.req == REQ_CLEAR) begin
          state_d = ST_CLR;
        end else begin
          state_d = sts_i.out_free ? ST_IDLE : ST_DONE;
        end
      end
      ST_RD_WAIT: begin
        state_d = sts_i.out_free ? ST_IDLE : ST_DONE;
      end
      ST_SCR_RD: begin
        state_d = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        state_d = sts_i.sw_copy_end ? ST_SCR_FILL : ST_SCR_RD;
      end
      ST_SCR_FILL: begin
        if (sts_i.sw_end) state_d = ST_DONE;
      end
      ST_CLR: begin
        if (sts_i.sw_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.zero_wr = 1'b1;
        cmd_o.sw_inc  = 1'b1;
      end
      ST_IDLE: begin
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        cmd_o.push = !exec_more && sts_i.out_free;
      end
      ST_RD_WAIT: begin
        cmd_o.cap_rd = 1'b1;
        cmd_o.push   = sts_i.out_free;
      end
      ST_SCR_RD: begin
        cmd_o.copy_rd = 1'b1;
      end
      ST_SCR_WR: begin
        cmd_o.copy_wr = 1'b1;
        cmd_o.sw_inc  = 1'b1;
      end
      ST_SCR_FILL, ST_CLR: begin
        cmd_o.zero_wr = 1'b1;
        cmd_o.sw_inc  = 1'b1;
      end
      ST_DONE: begin
        cmd_o.push = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  `TCW_ASSERT(a_accept_starts_exec, clk_i, rst_ni,
              (in_valid_i && !in_stall_o) |=> (state_q == ST_EXEC))
  `TCW_ASSERT(a_push_needs_room, clk_i, rst_ni, cmd_o.push |-> sts_i.out_free)
  `TCW_ASSERT_NR(a_no_push_in_reset, clk_i, !rst_ni |-> !cmd_o.push)

endmodule
`default_nettype wire
